>>> sv/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types and constants for the tag-to-elementary-stream block.
// ----------------------------------------------------------------------------
package fte_pkg;

   localparam logic [1:0] UK_PSET   = 2'd0;
   localparam logic [1:0] UK_VFRAME = 2'd1;
   localparam logic [1:0] UK_SPEC   = 2'd2;
   localparam logic [1:0] UK_AFRAME = 2'd3;

   localparam logic [1:0] KIND_VIDEO = 2'd0;
   localparam logic [1:0] KIND_AUDIO = 2'd1;

   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QAW    = 2;

   // one decoded job from front to back: an optional header run plus an optional byte
   typedef enum logic [1:0] {
      HDR_NONE,
      HDR_START,
      HDR_ADTS
   } hdr_type;

   typedef struct packed {
      hdr_type     hdr;
      logic [1:0]  hdr_kind;
      logic [31:0] hdr_pts;
      logic        has_byte;
      logic [1:0]  byte_kind;
      logic [7:0]  byte_val;
      logic [31:0] byte_pts;
      logic        last;
      logic [12:0] adts_len;
      logic [4:0]  profile;
      logic [3:0]  freq;
      logic [3:0]  chan;
   } job_type;

   typedef struct packed {
      logic [1:0]  unit_kind;
      logic [7:0]  out_byte;
      logic [31:0] pts;
      logic        unit_last;
      logic [4:0]  aac_profile;
      logic [3:0]  freq_index;
      logic [3:0]  channel_config;
   } rsp_type;

endpackage

>>> sv/fte_front.sv
// ----------------------------------------------------------------------------
// fte_front
// Body parser: walks each tag body and issues at most one job per accepted byte.
// ----------------------------------------------------------------------------
module fte_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       kind,
   input  logic [7:0]       body_byte,
   input  logic [23:0]      body_size,
   input  logic [31:0]      stamp,
   input  logic             stamp_abs,
   output logic             job_valid,
   input  logic             job_ready,
   output fte_pkg::job_type job
);
   import fte_pkg::*;

   typedef enum logic [3:0] {
      PH_START, PH_V_TYPE, PH_V_SEQ_PRE, PH_SPS_CNT, PH_SPS_LEN, PH_SPS_DATA,
      PH_PPS_CNT, PH_PPS_LEN, PH_PPS_DATA, PH_V_FRAME_HDR, PH_V_FRAME_DATA,
      PH_A_TYPE, PH_A_SPEC, PH_A_FRAME, PH_IGNORE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] idx_ff, idx_in;
   logic [7:0]  first_ff, first_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] left_ff, left_in;
   logic [1:0]  lcnt_ff, lcnt_in;
   logic        lfirst_ff, lfirst_in;
   logic [4:0]  prof_ff, prof_in;
   logic [3:0]  freq_ff, freq_in;
   logic [3:0]  chan_ff, chan_in;
   logic [31:0] vt_ff, vt_in;
   logic        vtv_ff, vtv_in;
   logic [31:0] at_ff, at_in;
   logic        atv_ff, atv_in;
   job_type     j;
   logic        emit;
   logic        fire;
   logic [15:0] sh16;
   logic [4:0]  cnt_dec;
   logic [31:0] left_dec;
   logic        is_pps;
   logic [1:0]  lc_next;
   logic        set_emitted;

   assign in_ready  = job_ready;
   assign fire      = in_valid && job_ready;
   assign job_valid = in_valid && emit;
   assign job       = j;
   assign sh16      = {left_ff[7:0], body_byte};

   always_comb begin
      phase_in  = phase_ff;
      first_in  = first_ff;
      cnt_in    = cnt_ff;
      left_in   = left_ff;
      lcnt_in   = lcnt_ff;
      lfirst_in = lfirst_ff;
      prof_in   = prof_ff;
      freq_in   = freq_ff;
      chan_in   = chan_ff;
      vt_in     = vt_ff;
      vtv_in    = vtv_ff;
      at_in     = at_ff;
      atv_in    = atv_ff;
      j          = '0;
      j.hdr      = HDR_NONE;
      j.profile  = prof_ff;
      j.freq     = freq_ff;
      j.chan     = chan_ff;
      j.adts_len = 13'(body_size + 24'd5);
      is_pps   = (phase_ff == PH_PPS_LEN) || (phase_ff == PH_PPS_DATA)
              || (phase_ff == PH_PPS_CNT);
      cnt_dec  = (cnt_ff != 5'd0) ? cnt_ff - 5'd1 : 5'd0;
      left_dec = (left_ff != 32'd0) ? left_ff - 32'd1 : 32'd0;
      lc_next  = lcnt_ff + 2'd1;
      set_emitted = 1'b0;
      unique case (phase_ff)
         PH_START: begin
            first_in = body_byte;
            phase_in = (kind == KIND_VIDEO) ? PH_V_TYPE :
                       (kind == KIND_AUDIO) ? PH_A_TYPE : PH_IGNORE;
         end
         PH_V_TYPE: begin
            left_in  = '0;
            phase_in = (body_byte == 8'd0) ? PH_V_SEQ_PRE : PH_V_FRAME_HDR;
         end
         PH_V_SEQ_PRE: if (idx_ff >= 24'd9) phase_in = PH_SPS_CNT;
         PH_SPS_CNT, PH_PPS_CNT: begin
            if (body_byte[4:0] == 5'd0) begin
               phase_in = is_pps ? PH_IGNORE : PH_PPS_CNT;
            end else begin
               cnt_in    = body_byte[4:0];
               lfirst_in = 1'b1;
               lcnt_in   = 2'd0;
               left_in   = '0;
               phase_in  = is_pps ? PH_PPS_LEN : PH_SPS_LEN;
            end
         end
         PH_SPS_LEN, PH_PPS_LEN: begin
            left_in = {16'd0, sh16};
            lcnt_in = lc_next;
            if (lc_next >= 2'd2) begin
               if (lfirst_ff) begin
                  j.hdr      = HDR_START;
                  j.hdr_kind = UK_PSET;
                  j.last     = (sh16 == 16'd0);
               end
               if (sh16 == 16'd0) set_emitted = 1'b1;
               else phase_in = is_pps ? PH_PPS_DATA : PH_SPS_DATA;
            end
         end
         PH_SPS_DATA, PH_PPS_DATA: begin
            if (lfirst_ff) begin
               j.has_byte  = 1'b1;
               j.byte_kind = UK_PSET;
               j.byte_val  = body_byte;
               j.last      = (left_dec == 32'd0);
            end
            left_in = left_dec;
            if (left_dec == 32'd0) set_emitted = 1'b1;
         end
         PH_V_FRAME_HDR: begin
            if (idx_ff >= 24'd5) left_in = {left_ff[23:0], body_byte};
            if (idx_ff >= 24'd8) begin
               vt_in  = (!vtv_ff || stamp_abs) ? stamp : vt_ff + stamp;
               vtv_in = 1'b1;
               j.hdr      = HDR_START;
               j.hdr_kind = UK_VFRAME;
               j.hdr_pts  = vt_in;
               j.last     = (left_in == 32'd0);
               phase_in   = (left_in == 32'd0) ? PH_IGNORE : PH_V_FRAME_DATA;
            end
         end
         PH_V_FRAME_DATA: begin
            j.has_byte  = 1'b1;
            j.byte_kind = UK_VFRAME;
            j.byte_val  = body_byte;
            j.byte_pts  = vt_ff;
            left_in     = left_dec;
            j.last      = (left_dec == 32'd0);
            if (left_dec == 32'd0) phase_in = PH_IGNORE;
         end
         PH_A_TYPE: begin
            if (body_byte == 8'd0) begin
               if (first_ff[7:4] == 4'd10) begin
                  left_in  = '0;
                  phase_in = PH_A_SPEC;
               end else begin
                  j.has_byte  = 1'b1;
                  j.byte_kind = UK_SPEC;
                  j.last      = 1'b1;
                  phase_in    = PH_IGNORE;
               end
            end else begin
               at_in  = (!atv_ff || stamp_abs) ? stamp : at_ff + stamp;
               atv_in = 1'b1;
               j.hdr      = HDR_ADTS;
               j.hdr_kind = UK_AFRAME;
               j.hdr_pts  = at_in;
               phase_in   = PH_A_FRAME;
            end
         end
         PH_A_SPEC: begin
            left_in = {16'd0, sh16};
            if (idx_ff >= 24'd3) begin
               prof_in = sh16[15:11];
               freq_in = sh16[10:7];
               chan_in = sh16[6:3];
               j.profile   = prof_in;
               j.freq      = freq_in;
               j.chan      = chan_in;
               j.has_byte  = 1'b1;
               j.byte_kind = UK_SPEC;
               j.last      = 1'b1;
               phase_in    = PH_IGNORE;
            end
         end
         PH_A_FRAME: begin
            j.has_byte  = 1'b1;
            j.byte_kind = UK_AFRAME;
            j.byte_val  = body_byte;
            j.byte_pts  = at_ff;
         end
         PH_IGNORE: ;
         default: ;
      endcase
      if (set_emitted) begin
         cnt_in    = cnt_dec;
         lcnt_in   = 2'd0;
         lfirst_in = 1'b0;
         left_in   = '0;
         if (cnt_dec != 5'd0) phase_in = is_pps ? PH_PPS_LEN : PH_SPS_LEN;
         else                 phase_in = is_pps ? PH_IGNORE : PH_PPS_CNT;
      end
      idx_in = idx_ff + 24'd1;
      if ({8'd0, idx_ff} + 32'd1 >= {8'd0, body_size}) begin
         j.last   = 1'b1;
         phase_in = PH_START;
         idx_in   = '0;
      end
      emit = (j.hdr != HDR_NONE) || j.has_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         idx_ff    <= '0;
         first_ff  <= '0;
         cnt_ff    <= '0;
         left_ff   <= '0;
         lcnt_ff   <= '0;
         lfirst_ff <= 1'b0;
         prof_ff   <= '0;
         freq_ff   <= '0;
         chan_ff   <= '0;
         vt_ff     <= '0;
         vtv_ff    <= 1'b0;
         at_ff     <= '0;
         atv_ff    <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         first_ff  <= first_in;
         cnt_ff    <= cnt_in;
         left_ff   <= left_in;
         lcnt_ff   <= lcnt_in;
         lfirst_ff <= lfirst_in;
         prof_ff   <= prof_in;
         freq_ff   <= freq_in;
         chan_ff   <= chan_in;
         vt_ff     <= vt_in;
         vtv_ff    <= vtv_in;
         at_ff     <= at_in;
         atv_ff    <= atv_in;
      end
   end

endmodule

>>> sv/fte_queue.sv
// ----------------------------------------------------------------------------
// fte_queue
// Small job FIFO between parser and emitter.
// ----------------------------------------------------------------------------
module fte_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  fte_pkg::job_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output fte_pkg::job_type rd_data
);
   import fte_pkg::*;

   job_type        mem_ff [QDEPTH];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0]   cnt_ff;
   logic           wr, rd;

   assign wr_ready = (cnt_ff != (QAW+1)'(QDEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr       = wr_valid && wr_ready;
   assign rd       = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + QAW'(1);
         if (rd) rp_ff <= rp_ff + QAW'(1);
         cnt_ff <= cnt_ff + (QAW+1)'(wr) - (QAW+1)'(rd);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == (QAW+1)'(QDEPTH) |-> !wr) else $error("queue overflow");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QAW+1)'(QDEPTH)) else $error("queue count out of range");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      wr && !rd |=> cnt_ff == $past(cnt_ff) + (QAW+1)'(1))
      else $error("queue count slip");
`endif

endmodule

>>> sv/fte_back.sv
// ----------------------------------------------------------------------------
// fte_back
// Emitter: expands each job into its start code or ADTS bytes, if any, and its data byte, if any.
// ----------------------------------------------------------------------------
module fte_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  fte_pkg::job_type job,
   output logic             out_valid,
   input  logic             out_ready,
   output fte_pkg::rsp_type out
);
   import fte_pkg::*;

   logic [2:0] step_ff;
   logic [2:0] nhdr;
   logic       in_hdr;
   logic       final_step;
   logic       take;
   logic [7:0] hb;
   logic [4:0] pm1;
   rsp_type    cur;
   rsp_type    out_ff;
   logic       ov_ff;
   logic       slot_free;

   assign nhdr = (job.hdr == HDR_START) ? 3'd4 : (job.hdr == HDR_ADTS) ? 3'd7 : 3'd0;
   assign in_hdr = step_ff < nhdr;
   assign final_step = job.has_byte ? (step_ff == nhdr) : (step_ff + 3'd1 == nhdr);
   assign slot_free = !ov_ff || out_ready;
   assign take = job_valid && slot_free;
   assign job_ready = take && final_step;
   assign out_valid = ov_ff;
   assign out = out_ff;
   assign pm1 = job.profile - 5'd1;

   always_comb begin
      hb = 8'd0;
      if (job.hdr == HDR_START) begin
         hb = (step_ff == 3'd3) ? 8'h01 : 8'h00;
      end else begin
         case (step_ff)
            3'd0:    hb = 8'hff;
            3'd1:    hb = 8'hf9;
            3'd2:    hb = {pm1[1:0], job.freq, 1'b0, job.chan[2]};
            3'd3:    hb = {job.chan[1:0], 4'd0, job.adts_len[12:11]};
            3'd4:    hb = job.adts_len[10:3];
            3'd5:    hb = {job.adts_len[2:0], 5'h1f};
            default: hb = 8'hfc;
         endcase
      end
      cur.aac_profile    = job.profile;
      cur.freq_index     = job.freq;
      cur.channel_config = job.chan;
      cur.unit_last      = final_step && job.last;
      if (in_hdr) begin
         cur.unit_kind = job.hdr_kind;
         cur.out_byte  = hb;
         cur.pts       = job.hdr_pts;
      end else begin
         cur.unit_kind = job.byte_kind;
         cur.out_byte  = job.byte_val;
         cur.pts       = job.byte_pts;
      end
   end

   always_ff @(posedge clock) begin
      if (take) out_ff <= cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         ov_ff   <= 1'b0;
      end else begin
         if (take) step_ff <= final_step ? 3'd0 : step_ff + 3'd1;
         if (slot_free) ov_ff <= take;
      end
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(out_ff)) else $error("result dropped");
   a_step: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 3'd7 && (job_valid || step_ff == 3'd0 || $past(job_valid)))
      else $error("step without job");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      job_ready |-> take) else $error("pop without beat");
`endif

endmodule

>>> sv/flv_tag_to_elementary_stream.sv
// ----------------------------------------------------------------------------
// flv_tag_to_elementary_stream
// FLV tag body to AVC Annex B / AAC ADTS byte stream.
// ----------------------------------------------------------------------------
// One body byte is taken per cycle while the queue has room. The parser issues
// at most one job per byte into a four-deep queue; the emitter sends one result
// beat per cycle while the output is ready, so a byte that opens an AVC unit
// costs four beats of output (start code) and an audio frame's second byte
// seven (ADTS header); any other byte costs at most one.
module flv_tag_to_elementary_stream (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] body_byte, [31:8] body_size, [63:32] stamp, [64] stamp_is_absolute
   input  logic [71:0] req_tdata,
   // [1:0] kind
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [39:8] pts, [44:40] aac_profile, [48:45] freq_index,
   // [52:49] channel_config
   output logic [55:0] rsp_tdata,
   // [1:0] unit_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import fte_pkg::*;

   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;
   rsp_type r;

   fte_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .kind(req_tuser), .body_byte(req_tdata[7:0]), .body_size(req_tdata[31:8]),
      .stamp(req_tdata[63:32]), .stamp_abs(req_tdata[64]),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   fte_queue u_queue (
      .clock, .reset,
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
   );

   fte_back u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out(r)
   );

   assign rsp_tdata = {3'd0, r.channel_config, r.freq_index, r.aac_profile,
                       r.pts, r.out_byte};
   assign rsp_tuser = r.unit_kind;
   assign rsp_tlast = r.unit_last;

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of flv_tag_to_elementary_stream: FLV tag bodies
// (AVC sequence headers, NALU frames, AAC specs and frames, ignored tags,
// short bodies) are fed byte by byte with random handshake gaps, and every
// output beat is compared against a behavioral parser model.
// ----------------------------------------------------------------------------
import fte_pkg::*;

class es_scoreboard;
   typedef enum int {
      PH_START, PH_V_TYPE, PH_V_SEQ_PRE, PH_SPS_CNT, PH_SPS_LEN, PH_SPS_DATA,
      PH_PPS_CNT, PH_PPS_LEN, PH_PPS_DATA, PH_V_FRAME_HDR, PH_V_FRAME_DATA,
      PH_A_TYPE, PH_A_SPEC, PH_A_FRAME, PH_IGNORE
   } phase_type;

   rsp_type     pending[$];
   int          errors;
   int          beats_seen;
   logic [23:0] pos;
   phase_type   phase;
   logic [7:0]  head_byte;
   logic [4:0]  sets_left;
   logic [31:0] remain;
   logic [31:0] lshift;
   logic [4:0]  prof;
   logic [3:0]  freq;
   logic [3:0]  chan;
   logic [31:0] vtime;
   logic        vtime_ok;
   logic [31:0] atime;
   logic        atime_ok;
   int          nnew;

   function void clear();
      pending.delete();
      errors = 0; beats_seen = 0;
      pos = 0; phase = PH_START; head_byte = 0; sets_left = 0;
      remain = 0; lshift = 0; prof = 0; freq = 0; chan = 0;
      vtime = 0; vtime_ok = 0; atime = 0; atime_ok = 0;
   endfunction

   function void push(logic [1:0] k, logic [7:0] b, logic [31:0] t);
      rsp_type r;
      if (nnew >= 8) return;
      r.unit_kind = k; r.out_byte = b; r.pts = t; r.unit_last = 0;
      r.aac_profile = prof; r.freq_index = freq; r.channel_config = chan;
      pending = {pending, r};
      nnew++;
   endfunction

   function void tag_last();
      if (nnew > 0) pending[pending.size()-1].unit_last = 1;
   endfunction

   function void start_code(logic [1:0] k, logic [31:0] t);
      push(k, 8'h00, t); push(k, 8'h00, t); push(k, 8'h00, t); push(k, 8'h01, t);
   endfunction

   function void entry_done(bit pps);
      if (sets_left > 0) sets_left--;
      lshift = 0; remain = 0;
      if (sets_left > 0) phase = pps ? PH_PPS_LEN : PH_SPS_LEN;
      else phase = pps ? PH_IGNORE : PH_PPS_CNT;
   endfunction

   function void note_input(logic [1:0] kind, logic [7:0] b, logic [23:0] size,
                            logic [31:0] stamp, logic absf);
      logic [31:0] cnt;
      logic [12:0] len;
      bit pps;
      nnew = 0;
      pps = phase inside {PH_PPS_CNT, PH_PPS_LEN, PH_PPS_DATA};
      case (phase)
         PH_START: begin
            head_byte = b;
            phase = kind == KIND_VIDEO ? PH_V_TYPE :
                    kind == KIND_AUDIO ? PH_A_TYPE : PH_IGNORE;
         end
         PH_V_TYPE: begin
            remain = 0;
            phase = b == 0 ? PH_V_SEQ_PRE : PH_V_FRAME_HDR;
         end
         PH_V_SEQ_PRE: if (pos >= 9) phase = PH_SPS_CNT;
         PH_SPS_CNT, PH_PPS_CNT: begin
            if (b[4:0] == 0) begin
               phase = pps ? PH_IGNORE : PH_PPS_CNT;
            end else begin
               sets_left = b[4:0]; lshift = 32'h10; remain = 0;
               phase = pps ? PH_PPS_LEN : PH_SPS_LEN;
            end
         end
         PH_SPS_LEN, PH_PPS_LEN: begin
            cnt = (lshift & 3) + 1;
            remain = ((remain << 8) | b) & 32'hFFFF;
            lshift = (lshift & ~32'd3) | (cnt & 3);
            if (cnt >= 2) begin
               if (lshift[4]) start_code(UK_PSET, 0);
               if (remain == 0) begin
                  if (lshift[4]) tag_last();
                  entry_done(pps);
               end else begin
                  phase = pps ? PH_PPS_DATA : PH_SPS_DATA;
               end
            end
         end
         PH_SPS_DATA, PH_PPS_DATA: begin
            if (lshift[4]) push(UK_PSET, b, 0);
            if (remain > 0) remain--;
            if (remain == 0) begin
               if (lshift[4]) tag_last();
               entry_done(pps);
            end
         end
         PH_V_FRAME_HDR: begin
            if (pos >= 5) remain = (remain << 8) | b;
            if (pos >= 8) begin
               if (!vtime_ok || absf) begin vtime_ok = 1; vtime = stamp; end
               else vtime = vtime + stamp;
               start_code(UK_VFRAME, vtime);
               if (remain == 0) begin
                  tag_last(); phase = PH_IGNORE;
               end else begin
                  phase = PH_V_FRAME_DATA;
               end
            end
         end
         PH_V_FRAME_DATA: begin
            push(UK_VFRAME, b, vtime);
            if (remain > 0) remain--;
            if (remain == 0) begin
               tag_last(); phase = PH_IGNORE;
            end
         end
         PH_A_TYPE: begin
            if (b == 0) begin
               if (head_byte[7:4] == 4'd10) begin
                  remain = 0; phase = PH_A_SPEC;
               end else begin
                  push(UK_SPEC, 0, 0); tag_last(); phase = PH_IGNORE;
               end
            end else begin
               if (!atime_ok || absf) begin atime_ok = 1; atime = stamp; end
               else atime = atime + stamp;
               len = 13'(size + 24'd5);
               push(UK_AFRAME, 8'hFF, atime);
               push(UK_AFRAME, 8'hF9, atime);
               push(UK_AFRAME, {2'(prof - 5'd1), freq, 1'b0, chan[2]}, atime);
               push(UK_AFRAME, {chan[1:0], 4'b0, len[12:11]}, atime);
               push(UK_AFRAME, len[10:3], atime);
               push(UK_AFRAME, {len[2:0], 5'h1F}, atime);
               push(UK_AFRAME, 8'hFC, atime);
               phase = PH_A_FRAME;
            end
         end
         PH_A_SPEC: begin
            remain = ((remain << 8) | b) & 32'hFFFF;
            if (pos >= 3) begin
               prof = remain[15:11]; freq = remain[10:7]; chan = remain[6:3];
               push(UK_SPEC, 0, 0); tag_last(); phase = PH_IGNORE;
            end
         end
         PH_A_FRAME: push(UK_AFRAME, b, atime);
         default: ;
      endcase
      if (32'(pos) + 1 >= 32'(size)) begin
         tag_last(); phase = PH_START; pos = 0;
      end else begin
         pos = pos + 1;
      end
   endfunction

   function void check_beat(rsp_type got);
      rsp_type exp_r;
      beats_seen++;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("ERROR: unexpected beat %p", got);
         return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
         errors++;
         if (errors <= 10) $display("ERROR: beat %0d expected %p got %p",
                                    beats_seen, exp_r, got);
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   es_scoreboard sb;
   int          cycles = 0;
   int          items_sent = 0;
   bit          calm = 0;
   logic [7:0]  body[$];

   flv_tag_to_elementary_stream dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_type r;
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            r.unit_kind = rsp_tuser; r.out_byte = rsp_tdata[7:0];
            r.pts = rsp_tdata[39:8]; r.unit_last = rsp_tlast;
            r.aac_profile = rsp_tdata[44:40]; r.freq_index = rsp_tdata[48:45];
            r.channel_config = rsp_tdata[52:49];
            sb.check_beat(r);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 22);
      end
   end

   task automatic send_beat(logic [1:0] kind, logic [7:0] b, logic [23:0] size,
                            logic [31:0] stamp, logic absf);
      while (!calm && $urandom_range(99) < 22) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {7'b0, absf, stamp, size, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(kind, b, size, stamp, absf);
      items_sent++;
   endtask

   task automatic send_body(logic [1:0] kind, logic [31:0] stamp, logic absf);
      for (int i = 0; i < body.size(); i++)
         send_beat(kind, body[i], 24'(body.size()), stamp, absf);
      req_tvalid <= 0;
   endtask

   task automatic avc_seq(int sps_n, int pps_n, int slen, int plen);
      body = {8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h64, 8'h00, 8'h1F,
              8'hFF, 8'hE0 | 8'(sps_n)};
      for (int e = 0; e < sps_n; e++) begin
         body = {body, 8'h00, 8'(slen)};
         for (int i = 0; i < slen; i++) body = {body, 8'($urandom)};
      end
      body = {body, 8'(pps_n)};
      for (int e = 0; e < pps_n; e++) begin
         body = {body, 8'h00, 8'(plen)};
         for (int i = 0; i < plen; i++) body = {body, 8'($urandom)};
      end
   endtask

   task automatic avc_frame(int nlen, int extra);
      body = {8'h27, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'(nlen)};
      for (int i = 0; i < nlen + extra; i++) body = {body, 8'($urandom)};
   endtask

   task automatic aac_spec(logic [3:0] fmt, logic [15:0] cfg);
      body = {{fmt, 4'hF}, 8'h00, cfg[15:8], cfg[7:0]};
   endtask

   task automatic aac_frame(int n);
      body = {8'hAF, 8'h01};
      for (int i = 0; i < n; i++) body = {body, 8'($urandom)};
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int sel;
      sb = new();
      sb.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      avc_seq(1, 1, 2, 1);               send_body(KIND_VIDEO, 32'h0, 0);
      avc_seq(0, 0, 0, 0);               send_body(KIND_VIDEO, 32'h0, 0);
      calm = 1;
      avc_seq(2, 2, 0, 0);               send_body(KIND_VIDEO, 32'h0, 0);
      avc_frame(2, 1);                   send_body(KIND_VIDEO, 32'hFFFF_FFF0, 0);
      avc_frame(0, 0);                   send_body(KIND_VIDEO, 32'h20, 0);
      calm = 0;
      aac_spec(4'hA, 16'hFFFF);          send_body(KIND_AUDIO, 0, 0);
      aac_frame(2);                      send_body(KIND_AUDIO, 32'hFFFF_FFFF, 1);
      aac_spec(4'h2, 16'h1234);          send_body(KIND_AUDIO, 0, 0);
      aac_frame(1);                      send_body(KIND_AUDIO, 32'h7, 0);
      body = {8'hFF, 8'h00, 8'h55};      send_body(2'd2, 32'hFFFF_FFFF, 1);
      body = {8'h12, 8'hFF};             send_body(2'd3, 0, 0);
      avc_frame(4, 0); body = body[0:6]; send_body(KIND_VIDEO, 1, 0);
      send_beat(KIND_AUDIO, 8'hAF, 24'hFFFFFF, 0, 0);
      send_beat(KIND_AUDIO, 8'h01, 24'hFFFFFF, 32'h1, 0);
      send_beat(KIND_AUDIO, 8'h00, 24'd1, 32'h1, 0);
      send_beat(KIND_VIDEO, 8'hAA, 24'd1, 0, 0);
      drain();

      for (int t = 0; t < 40 && items_sent < 110; t++) begin
         sel = $urandom_range(9);
         case (sel)
            0, 1: avc_seq($urandom_range(2), $urandom_range(2),
                          $urandom_range(3), $urandom_range(3));
            2, 3, 4: avc_frame($urandom_range(5), $urandom_range(1));
            5: aac_spec($urandom_range(1) ? 4'hA : 4'($urandom), 16'($urandom));
            6, 7: aac_frame($urandom_range(4));
            8: begin
               avc_frame($urandom_range(4), 0);
               body = body[0:$urandom_range(body.size()-1)];
            end
            default: begin
               body.delete();
               repeat ($urandom_range(1, 4)) body = {body, 8'($urandom)};
            end
         endcase
         send_body(sel < 5 || sel == 8 ? KIND_VIDEO : sel < 8 ? KIND_AUDIO :
                   2'($urandom_range(3)), $urandom, $urandom_range(1));
      end
      calm = 0;
      drain();
      $display("Covered %0d body bytes and %0d output beats: AVC headers, NALUs,",
               items_sent, sb.beats_seen);
      $display("AAC specs and ADTS frames, ignored tags and truncated bodies.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

>>> flv_tag_to_elementary_stream.f
sv/fte_pkg.sv
sv/fte_front.sv
sv/fte_queue.sv
sv/fte_back.sv
sv/flv_tag_to_elementary_stream.sv
verif/tb.sv
